// ===== design/lrutc_pkg.sv =====
package lrutc_pkg;

	localparam int DEF_SLOTS_PER_POOL = 64;

	localparam int OP_W     = 3;
	localparam int SLOT_W   = 6;
	localparam int STATUS_W = 2;
	localparam int CNT_W    = 8;
	localparam int MAXC_W   = 10;
	localparam int FRAME_W  = 16;

	localparam logic [OP_W-1:0] OP_TOUCH = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
	localparam logic [OP_W-1:0] OP_EVICT = 3'd2;
	localparam logic [OP_W-1:0] OP_TICK  = 3'd3;
	localparam logic [OP_W-1:0] OP_INVAL = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_HIT     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_REQ     = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_PENDING = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd3;

	localparam logic [MAXC_W-1:0]  MAX_CACHED_RESET = 10'd512;
	localparam logic [FRAME_W-1:0] FRAME_MAX        = 16'hFFFF;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_item;
		logic exec_apply;
		logic evict_setup;
		logic scan_start;
		logic scan_en;
		logic min_pass;
		logic finish_evict;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic is_evict;
		logic evict_none;
		logic scan_last;
		logic remain_zero;
	} stat_t;

endpackage

// ===== design/lru_texture_cache_policy_unit.sv =====
// LRU residency policy for an object and a background tile pool, one result per operation.
// Touch, load done, frame tick and invalidate take the transfer into the unit and an
// execute step that writes the result register, held while an earlier result waits on
// out_stall; the next item is taken once that step has run, even while its own result
// waits. An evict runs a round per distinct last-used frame among the dropped tiles, none
// when nothing is to be dropped: each round is one scan of the timestamp RAM to find the
// oldest frame and one scan to drop the tiles stamped with it, in slot order, at one RAM
// read per cycle. No clearing pass follows reset; resident flags gate every timestamp read.
module lru_texture_cache_policy_unit import lrutc_pkg::*; #(
	parameter int SLOTS_PER_POOL = DEF_SLOTS_PER_POOL
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     operation,
	input  logic                pool,
	input  logic [SLOT_W-1:0]   slot,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [CNT_W-1:0]    evicted_count,
	output logic [CNT_W-1:0]    resident_count,
	input  logic                max_cached_we,
	input  logic [MAXC_W-1:0]   max_cached
);

	cmd_t  cmd;
	stat_t stat;

	lrutc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	lrutc_datapath #(
		.SLOTS_PER_POOL(SLOTS_PER_POOL)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.operation     (operation),
		.pool          (pool),
		.slot          (slot),
		.max_cached_we (max_cached_we),
		.max_cached    (max_cached),
		.status        (status),
		.evicted_count (evicted_count),
		.resident_count(resident_count)
	);

endmodule

// ===== design/lrutc_ram.sv =====
module lrutc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/lrutc_datapath.sv =====
module lrutc_datapath import lrutc_pkg::*; #(
	parameter int SLOTS_PER_POOL = DEF_SLOTS_PER_POOL
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output stat_t               stat,
	input  logic [OP_W-1:0]     operation,
	input  logic                pool,
	input  logic [SLOT_W-1:0]   slot,
	input  logic                max_cached_we,
	input  logic [MAXC_W-1:0]   max_cached,
	output logic [STATUS_W-1:0] status,
	output logic [CNT_W-1:0]    evicted_count,
	output logic [CNT_W-1:0]    resident_count
);

	localparam int N  = 2 * SLOTS_PER_POOL;
	localparam int IW = $clog2(N);
	localparam int CW = $clog2(N + 1);
	localparam int DW = ((CW > MAXC_W) ? CW : MAXC_W) + 1;

	logic [OP_W-1:0]    op_q;
	logic               pool_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [MAXC_W-1:0]  max_cached_q;
	logic [FRAME_W-1:0] frame_q;
	logic [N-1:0]       resident_q;
	logic [N-1:0]       pending_q;
	logic [CW-1:0]      res_cnt_q;
	logic [CW-1:0]      remain_q;
	logic [CNT_W-1:0]   evicted_q;
	logic [IW:0]        scan_cnt_q;
	logic               rd_v_s1;
	logic [IW-1:0]      rd_idx_s1;
	logic [FRAME_W-1:0] min_q;
	logic               found_q;
	logic [STATUS_W-1:0] status_q;
	logic [CNT_W-1:0]   evicted_out_q;
	logic [CNT_W-1:0]   resident_out_q;

	logic               in_range;
	logic [IW-1:0]      idx;
	logic               cur_res;
	logic               cur_pend;
	logic [STATUS_W-1:0] exec_status;
	logic [CW-1:0]      res_cnt_next;
	logic               issue;
	logic [FRAME_W-1:0] rdata;
	logic               ram_we;
	logic               rd_res;
	logic               min_upd;
	logic               drop_hit;
	logic [DW-1:0]      cnt_w;
	logic [DW-1:0]      max_w;
	logic [DW-1:0]      drop_raw;
	logic [DW-1:0]      drop_w;
	logic               evict_none;

	assign in_range = 32'(slot_q) < SLOTS_PER_POOL;
	assign idx      = pool_q ? (IW'(SLOTS_PER_POOL) + IW'(slot_q)) : IW'(slot_q);
	assign cur_res  = in_range && resident_q[idx];
	assign cur_pend = in_range && pending_q[idx];

	always_comb begin
		exec_status  = STAT_DONE;
		res_cnt_next = res_cnt_q;
		case (op_q)
			OP_TOUCH: begin
				if (in_range) begin
					if (cur_res) begin
						exec_status = STAT_HIT;
					end else if (!cur_pend) begin
						exec_status = STAT_REQ;
					end else begin
						exec_status = STAT_PENDING;
					end
				end
			end
			OP_LOAD: begin
				if (in_range && !cur_res) begin
					res_cnt_next = res_cnt_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// drop count for an evict: count - limit + limit/4, clipped to count
	assign cnt_w      = DW'(res_cnt_q);
	assign max_w      = DW'(max_cached_q);
	assign drop_raw   = cnt_w - max_w + (max_w >> 2);
	assign drop_w     = (drop_raw > cnt_w) ? cnt_w : drop_raw;
	assign evict_none = (max_cached_q == '0) || (cnt_w < max_w);

	assign issue    = cmd.scan_en && (scan_cnt_q < (IW + 1)'(N));
	assign ram_we   = cmd.exec_apply && in_range &&
	                  ((op_q == OP_TOUCH && cur_res) || op_q == OP_LOAD);
	assign rd_res   = rd_v_s1 && resident_q[rd_idx_s1];
	assign min_upd  = cmd.scan_en && cmd.min_pass && rd_res &&
	                  (!found_q || rdata < min_q);
	assign drop_hit = cmd.scan_en && !cmd.min_pass && rd_res &&
	                  (rdata == min_q) && (remain_q != '0);

	lrutc_ram #(
		.WIDTH(FRAME_W),
		.DEPTH(N)
	) u_stamp_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx),
		.wdata(frame_q),
		.raddr(scan_cnt_q[IW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cached_q <= MAX_CACHED_RESET;
			frame_q      <= '0;
			resident_q   <= '0;
			pending_q    <= '0;
			res_cnt_q    <= '0;
			remain_q     <= '0;
			scan_cnt_q   <= '0;
			rd_v_s1      <= 1'b0;
			found_q      <= 1'b0;
		end else begin
			if (max_cached_we) begin
				max_cached_q <= max_cached;
			end
			if (cmd.exec_apply) begin
				res_cnt_q <= res_cnt_next;
				case (op_q)
					OP_TOUCH: begin
						if (in_range && !cur_res) begin
							pending_q[idx] <= 1'b1;
						end
					end
					OP_LOAD: begin
						if (in_range) begin
							resident_q[idx] <= 1'b1;
						end
					end
					OP_TICK: begin
						if (frame_q != FRAME_MAX) begin
							frame_q <= frame_q + 16'd1;
						end
					end
					OP_INVAL: begin
						pending_q <= '0;
						frame_q   <= '0;
						if (max_cached_q == '0) begin
							max_cached_q <= MAX_CACHED_RESET;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.evict_setup) begin
				remain_q <= evict_none ? '0 : CW'(drop_w);
			end
			if (drop_hit) begin
				resident_q[rd_idx_s1] <= 1'b0;
				remain_q              <= remain_q - CW'(1);
				res_cnt_q             <= res_cnt_q - CW'(1);
			end
			// restart the stamp scan
			if (cmd.scan_start) begin
				scan_cnt_q <= '0;
				rd_v_s1    <= 1'b0;
				found_q    <= 1'b0;
			end else begin
				rd_v_s1 <= issue;
				if (issue) begin
					scan_cnt_q <= scan_cnt_q + (IW + 1)'(1);
				end
				if (min_upd) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q   <= operation;
			pool_q <= pool;
			slot_q <= slot;
		end
		if (cmd.evict_setup) begin
			evicted_q <= evict_none ? '0 : CNT_W'(drop_w);
		end
		rd_idx_s1 <= scan_cnt_q[IW-1:0];
		if (min_upd) begin
			min_q <= rdata;
		end
		if (cmd.exec_apply) begin
			status_q       <= exec_status;
			evicted_out_q  <= '0;
			resident_out_q <= CNT_W'(res_cnt_next);
		end else if (cmd.finish_evict) begin
			status_q       <= STAT_DONE;
			evicted_out_q  <= evicted_q;
			resident_out_q <= CNT_W'(res_cnt_q);
		end
	end

	assign stat.is_evict    = (op_q == OP_EVICT);
	assign stat.evict_none  = evict_none;
	assign stat.scan_last   = rd_v_s1 && (rd_idx_s1 == IW'(N - 1));
	assign stat.remain_zero = (remain_q == '0);

	assign status         = status_q;
	assign evicted_count  = evicted_out_q;
	assign resident_count = resident_out_q;

	a_count_matches_flags: assert property (@(posedge clk) disable iff (!arst_n)
		32'(res_cnt_q) == $countones(resident_q))
		else $error("resident counter out of step with resident flags");

	a_evict_fully_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish_evict |-> remain_q == '0)
		else $error("evict finished with tiles left to drop");

	a_frame_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.exec_apply && op_q == OP_INVAL) |=> frame_q >= $past(frame_q))
		else $error("frame counter went back without an invalidate");

endmodule

// ===== design/lrutc_ctrl.sv =====
module lrutc_ctrl import lrutc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_MIN   = 3'd2;
	localparam logic [2:0] S_DROP  = 3'd3;
	localparam logic [2:0] S_CHECK = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_next;
	logic       out_valid_q;
	logic       slot_free;

	assign in_stall  = (state_q != S_IDLE);
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_next    = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.is_evict) begin
					cmd.evict_setup = 1'b1;
					if (stat.evict_none) begin
						state_next = S_DONE;
					end else begin
						cmd.scan_start = 1'b1;
						state_next     = S_MIN;
					end
				end else if (slot_free) begin
					cmd.exec_apply = 1'b1;
					state_next     = S_IDLE;
				end
			end
			S_MIN: begin
				cmd.scan_en  = 1'b1;
				cmd.min_pass = 1'b1;
				if (stat.scan_last) begin
					cmd.scan_start = 1'b1;
					state_next     = S_DROP;
				end
			end
			S_DROP: begin
				cmd.scan_en = 1'b1;
				if (stat.scan_last) begin
					state_next = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.remain_zero) begin
					state_next = S_DONE;
				end else begin
					cmd.scan_start = 1'b1;
					state_next     = S_MIN;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.finish_evict = 1'b1;
					state_next       = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			// hold the result until its transfer completes
			if (cmd.exec_apply || cmd.finish_evict) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== tb/lru_policy_checker.sv =====
`timescale 1ns / 100ps

module lru_policy_checker import lrutc_pkg::*; #(
	parameter int SLOTS_PER_POOL = DEF_SLOTS_PER_POOL
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [OP_W-1:0]     operation,
	input  logic                pool,
	input  logic [SLOT_W-1:0]   slot,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [STATUS_W-1:0] status,
	input  logic [CNT_W-1:0]    evicted_count,
	input  logic [CNT_W-1:0]    resident_count,
	input  logic                max_cached_we,
	input  logic [MAXC_W-1:0]   max_cached,
	output int                  outstanding,
	output int                  failures
);

	localparam int ENTRIES = 2 * SLOTS_PER_POOL;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CNT_W-1:0]    evicted;
		logic [CNT_W-1:0]    resident;
	} outcome_t;

	outcome_t           outcome_q[$];
	outcome_t           due;
	logic               is_resident [ENTRIES];
	logic               is_pending  [ENTRIES];
	logic [FRAME_W-1:0] stamp       [ENTRIES];
	logic [FRAME_W-1:0] frame_now;
	logic [MAXC_W-1:0]  limit;

	function automatic int count_resident();
		int n;
		n = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (is_resident[i])
				n++;
		return n;
	endfunction

	// drop the oldest tiles; a strict compare keeps the lowest index on a tie,
	// which puts the object pool ahead of the background pool
	function automatic int drop_oldest();
		int total;
		int drop;
		int oldest;
		total = count_resident();
		if (limit == '0 || total < int'(limit))
			return 0;
		drop = total - int'(limit) + int'(limit) / 4;
		if (drop > total)
			drop = total;
		for (int k = 0; k < drop; k++) begin
			oldest = -1;
			for (int i = 0; i < ENTRIES; i++)
				if (is_resident[i] && (oldest < 0 || stamp[i] < stamp[oldest]))
					oldest = i;
			is_resident[oldest] = 1'b0;
		end
		return drop;
	endfunction

	function automatic outcome_t predict(input logic [OP_W-1:0] op, input logic pl,
			input logic [SLOT_W-1:0] sl);
		outcome_t res;
		int       idx;
		logic     in_range;
		in_range    = int'(sl) < SLOTS_PER_POOL;
		idx         = int'(pl) * SLOTS_PER_POOL + int'(sl);
		res.status  = STAT_DONE;
		res.evicted = '0;
		case (op)
			OP_TOUCH: begin
				if (in_range) begin
					if (is_resident[idx]) begin
						stamp[idx] = frame_now;
						res.status = STAT_HIT;
					end else if (!is_pending[idx]) begin
						is_pending[idx] = 1'b1;
						res.status      = STAT_REQ;
					end else begin
						res.status = STAT_PENDING;
					end
				end
			end
			OP_LOAD: begin
				// pending stays set until the next invalidate
				if (in_range) begin
					is_resident[idx] = 1'b1;
					stamp[idx]       = frame_now;
				end
			end
			OP_EVICT: begin
				res.evicted = CNT_W'(drop_oldest());
			end
			OP_TICK: begin
				if (frame_now != FRAME_MAX)
					frame_now = frame_now + 1'b1;
			end
			OP_INVAL: begin
				for (int i = 0; i < ENTRIES; i++)
					is_pending[i] = 1'b0;
				frame_now = '0;
				if (limit == '0)
					limit = MAX_CACHED_RESET;
			end
			default: begin
			end
		endcase
		res.resident = CNT_W'(count_resident());
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				is_resident[i] = 1'b0;
				is_pending[i]  = 1'b0;
				stamp[i]       = '0;
			end
			frame_now = '0;
			limit     = MAX_CACHED_RESET;
			outcome_q.delete();
			outstanding = 0;
			failures    = 0;
		end else begin
			if (max_cached_we)
				limit = max_cached;
			if (out_valid && !out_stall) begin
				if (outcome_q.size() == 0) begin
					$error("unexpected result transfer: status %0d evicted %0d resident %0d",
						status, evicted_count, resident_count);
					failures++;
				end else begin
					due = outcome_q.pop_front();
					if (status !== due.status) begin
						$error("status: expected %0d, got %0d", due.status, status);
						failures++;
					end
					if (evicted_count !== due.evicted) begin
						$error("evicted_count: expected %0d, got %0d", due.evicted,
							evicted_count);
						failures++;
					end
					if (resident_count !== due.resident) begin
						$error("resident_count: expected %0d, got %0d", due.resident,
							resident_count);
						failures++;
					end
				end
			end
			if (in_valid && !in_stall)
				outcome_q = {outcome_q, predict(operation, pool, slot)};
			outstanding = outcome_q.size();
		end
	end

endmodule

// ===== tb/lru_texture_cache_policy_unit_tb.sv =====
`timescale 1ns / 100ps

module lru_texture_cache_policy_unit_tb import lrutc_pkg::*;;

	localparam int IDLE_LIMIT   = 200000;
	localparam int LONG_HOLD    = 400;
	localparam int LONG_HOLD_AT = 300;
	localparam int PHASE_ITEMS  = 130;

	// operation codes the block does not use
	localparam logic [OP_W-1:0] OP_RSVD0 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD1 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD2 = 3'd7;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [OP_W-1:0]     operation;
	logic                pool;
	logic [SLOT_W-1:0]   slot;
	logic                out_valid;
	logic                out_stall;
	logic [STATUS_W-1:0] status;
	logic [CNT_W-1:0]    evicted_count;
	logic [CNT_W-1:0]    resident_count;
	logic                max_cached_we;
	logic [MAXC_W-1:0]   max_cached;

	int outstanding;
	int failures;
	int idle_cycles;
	int results_seen;
	bit tx_calm;
	bit rx_calm;

	lru_texture_cache_policy_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.pool           (pool),
		.slot           (slot),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.evicted_count  (evicted_count),
		.resident_count (resident_count),
		.max_cached_we  (max_cached_we),
		.max_cached     (max_cached)
	);

	lru_policy_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.pool           (pool),
		.slot           (slot),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.evicted_count  (evicted_count),
		.resident_count (resident_count),
		.max_cached_we  (max_cached_we),
		.max_cached     (max_cached),
		.outstanding    (outstanding),
		.failures       (failures)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("lru_texture_cache_policy_unit verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: random hold-offs, one long one while the sender keeps going
	initial begin
		int hold;
		out_stall    <= 1'b0;
		results_seen = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (results_seen == LONG_HOLD_AT)
				hold = LONG_HOLD;
			else
				hold = rx_calm ? 0 : $urandom_range(0, 11);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!(out_valid && !out_stall)) @(posedge clk);
			results_seen++;
		end
	end

	task automatic send_item(input logic [OP_W-1:0] op, input logic pl,
			input logic [SLOT_W-1:0] sl);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		pool      <= pl;
		slot      <= sl;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// hold the input until every result is back, then write the limit
	task automatic set_limit(input logic [MAXC_W-1:0] value);
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		@(posedge clk);
		max_cached_we <= 1'b1;
		max_cached    <= value;
		@(posedge clk);
		max_cached_we <= 1'b0;
	endtask

	task automatic random_traffic(input int count);
		int                left;
		int                pick;
		logic              pl;
		logic [SLOT_W-1:0] sl;
		left = count;
		while (left > 0) begin
			pick = $urandom_range(0, 99);
			pl   = 1'($urandom_range(0, 1));
			sl   = SLOT_W'($urandom_range(0, (1 << SLOT_W) - 1));
			if (pick < 30) begin
				// request, fill, then hit on the same tile
				send_item(OP_TOUCH, pl, sl);
				send_item(OP_LOAD, pl, sl);
				send_item(OP_TOUCH, pl, sl);
				left -= 3;
			end else begin
				if (pick < 52)
					send_item(OP_TOUCH, pl, sl);
				else if (pick < 74)
					send_item(OP_LOAD, pl, sl);
				else if (pick < 81)
					send_item(OP_EVICT, pl, sl);
				else if (pick < 87)
					send_item(OP_TICK, pl, sl);
				else if (pick < 91)
					send_item(OP_INVAL, pl, sl);
				else if (pick < 94)
					send_item(OP_W'($urandom_range(OP_RSVD0, OP_RSVD2)), pl, sl);
				else
					send_item(OP_TOUCH, pl, sl);
				left--;
			end
		end
	endtask

	initial begin
		logic [MAXC_W-1:0] limits[10];
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		operation     <= OP_TOUCH;
		pool          <= 1'b0;
		slot          <= '0;
		max_cached_we <= 1'b0;
		max_cached    <= '0;
		tx_calm       = 1'b0;
		rx_calm       = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		set_limit(10'd4);
		send_item(OP_TOUCH, 1'b0, 6'd0);
		send_item(OP_TOUCH, 1'b0, 6'd0);
		send_item(OP_LOAD, 1'b0, 6'd0);
		send_item(OP_TOUCH, 1'b0, 6'd0);
		send_item(OP_TOUCH, 1'b1, 6'd63);
		send_item(OP_LOAD, 1'b1, 6'd63);
		send_item(OP_TICK, 1'b0, 6'd0);
		send_item(OP_LOAD, 1'b0, 6'd63);
		send_item(OP_TICK, 1'b1, 6'd63);
		send_item(OP_LOAD, 1'b1, 6'd0);
		send_item(OP_TOUCH, 1'b0, 6'd0);
		send_item(OP_EVICT, 1'b0, 6'd0);
		// pending survives the load and the evict
		send_item(OP_TOUCH, 1'b1, 6'd63);
		send_item(OP_RSVD0, 1'b1, 6'd63);
		send_item(OP_RSVD1, 1'b0, 6'd21);
		send_item(OP_RSVD2, 1'b1, 6'd42);
		send_item(OP_INVAL, 1'b0, 6'd0);
		send_item(OP_TOUCH, 1'b1, 6'd63);
		send_item(OP_LOAD, 1'b1, 6'd63);
		// same stamp in both pools: the evict drops both tiles
		send_item(OP_LOAD, 1'b0, 6'd5);
		send_item(OP_EVICT, 1'b1, 6'd0);
		send_item(OP_EVICT, 1'b0, 6'd0);

		// back-to-back ticks at full rate
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		repeat (40) send_item(OP_TICK, 1'b0, 6'd0);
		send_item(OP_TOUCH, 1'b0, 6'd0);
		send_item(OP_LOAD, 1'b1, 6'd1);
		send_item(OP_LOAD, 1'b1, 6'd2);
		send_item(OP_EVICT, 1'b0, 6'd0);
		send_item(OP_INVAL, 1'b0, 6'd0);

		limits = '{10'd1, 10'd0, 10'd1023, 10'd16, 10'd4, 10'd127, 10'd40, 10'd2,
			10'd128, 10'd0};
		limits[9] = MAXC_W'($urandom_range(0, 130));
		for (int ph = 0; ph < 10; ph++) begin
			set_limit(limits[ph]);
			tx_calm = (ph % 3 == 2);
			rx_calm = (ph % 4 == 1);
			random_traffic(PHASE_ITEMS);
		end

		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (16) @(posedge clk);
		if (failures == 0)
			$display("lru_texture_cache_policy_unit verification clean");
		else
			$display("lru_texture_cache_policy_unit verification failed");
		$finish;
	end

endmodule
